FILE: rtl/core/datc_pkg.sv
// Shared types and constants for the decimal amount parser.
// Used by datc_front, datc_back and the top level.
package datc_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned DigW      = 4;
  localparam int unsigned WholeW    = 60;
  localparam int unsigned FracW     = 7;
  localparam int unsigned AmountW   = 63;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // floor(INT64_MAX / 100); the limit drops by one when the addend exceeds 7
  localparam logic [WholeW-1:0] WholeLimit = 60'd92233720368547758;
  localparam logic [DigW-1:0]   LimitDig   = 4'd7;

  typedef enum logic [2:0] {
    TK_WS,
    TK_DIG,
    TK_PT,
    TK_OTH,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e       kind;
    logic [DigW-1:0] dig;
  } token_t;

endpackage

FILE: rtl/core/datc_front.sv
// Front end: classifies each input byte into a token and queues it.
// Depends on datc_pkg.
module datc_front import datc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [ChW-1:0] ch_i,
  output logic           tok_valid_o,
  output token_t         tok_o,
  input  logic           tok_pop_i
);

  localparam logic [ChW-1:0] ChNul   = 8'd0;
  localparam logic [ChW-1:0] ChSpace = 8'd32;
  localparam logic [ChW-1:0] ChTab   = 8'd9;
  localparam logic [ChW-1:0] ChCr    = 8'd13;
  localparam logic [ChW-1:0] ChZero  = 8'd48;
  localparam logic [ChW-1:0] ChNine  = 8'd57;
  localparam logic [ChW-1:0] ChPoint = 8'd46;

  token_t              tok_c;
  logic [ChW-1:0]      dig_full;
  token_t              q_mem [QDepth];
  logic [QAddrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [QCntW-1:0]    cnt_q, cnt_d;
  logic                push, pop;

  always_comb begin
    dig_full  = ch_i - ChZero;
    tok_c.dig = dig_full[DigW-1:0];
    if (ch_i == ChNul) begin
      tok_c.kind = TK_END;
    end else if (ch_i == ChSpace || (ch_i >= ChTab && ch_i <= ChCr)) begin
      tok_c.kind = TK_WS;
    end else if (ch_i >= ChZero && ch_i <= ChNine) begin
      tok_c.kind = TK_DIG;
    end else if (ch_i == ChPoint) begin
      tok_c.kind = TK_PT;
    end else begin
      tok_c.kind = TK_OTH;
    end
  end

  assign in_ready_o  = (cnt_q != QCntW'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign tok_valid_o = (cnt_q != '0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = q_mem[head_q];

  always_comb begin
    head_d = pop ? head_q + 1'b1 : head_q;
    tail_d = push ? tail_q + 1'b1 : tail_q;
    cnt_d  = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[tail_q] <= tok_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/datc_back.sv
// Back end: runs the amount grammar on queued tokens and forms the result.
// Depends on datc_pkg.
module datc_back import datc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  token_t             tok_i,
  output logic               tok_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic [AmountW-1:0] amount_o
);

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_FRAC  = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [WholeW-1:0] whole_q, whole_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [1:0]        fcnt_q, fcnt_d;
  logic              seen_dig_q, seen_dig_d;
  logic              seen_pt_q, seen_pt_d;

  logic              a_vld_q, a_bad_q, a_bad_d;
  logic [WholeW-1:0] a_whole_q;
  logic [FracW-1:0]  a_frac_q, frac_s;
  logic              b_vld_q, b_status_q;
  logic [AmountW-1:0] b_amount_q, b_amount_d;

  logic a_en, b_en, is_end, step, int_ok;
  logic [WholeW-1:0] int_next;

  assign b_en      = !b_vld_q || out_ready_i;
  assign a_en      = !a_vld_q || b_en;
  assign is_end    = (tok_i.kind == TK_END);
  assign tok_pop_o = tok_valid_i && (!is_end || a_en);
  assign step      = tok_pop_o;

  assign int_ok   = whole_q <= (WholeLimit - WholeW'(tok_i.dig > LimitDig));
  assign int_next = (whole_q << 3) + (whole_q << 1) + WholeW'(tok_i.dig);

  always_comb begin
    phase_d    = phase_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    fcnt_d     = fcnt_q;
    seen_dig_d = seen_dig_q;
    seen_pt_d  = seen_pt_q;
    if (is_end) begin
      phase_d    = PH_LEAD;
      whole_d    = '0;
      frac_d     = '0;
      fcnt_d     = '0;
      seen_dig_d = 1'b0;
      seen_pt_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_LEAD, PH_INT: begin
          if (tok_i.kind == TK_DIG) begin
            if (int_ok) begin
              whole_d    = int_next;
              seen_dig_d = 1'b1;
              phase_d    = PH_INT;
            end else begin
              phase_d = PH_ERR;
            end
          end else if (tok_i.kind == TK_PT) begin
            seen_pt_d = 1'b1;
            phase_d   = PH_FRAC;
          end else if (tok_i.kind == TK_WS) begin
            phase_d = (phase_q == PH_INT) ? PH_TRAIL : PH_LEAD;
          end else begin
            phase_d = PH_ERR;
          end
        end
        PH_FRAC: begin
          if (tok_i.kind == TK_DIG) begin
            if (fcnt_q >= 2'd2) begin
              phase_d = PH_ERR;
            end else begin
              frac_d     = FracW'((frac_q << 3) + (frac_q << 1)) + FracW'(tok_i.dig);
              fcnt_d     = fcnt_q + 2'd1;
              seen_dig_d = 1'b1;
            end
          end else if (tok_i.kind == TK_WS) begin
            phase_d = PH_TRAIL;
          end else begin
            phase_d = PH_ERR;
          end
        end
        PH_TRAIL: begin
          if (tok_i.kind != TK_WS) begin
            phase_d = PH_ERR;
          end
        end
        default: phase_d = PH_ERR;
      endcase
    end
  end

  // scaled fraction and validity of the finished string
  always_comb begin
    case (fcnt_q)
      2'd0:    frac_s = '0;
      2'd1:    frac_s = FracW'((frac_q << 3) + (frac_q << 1));
      default: frac_s = frac_q;
    endcase
    a_bad_d = (phase_q >= PH_ERR) || !seen_dig_q || (seen_pt_q && fcnt_q == 2'd0)
           || (whole_q > (WholeLimit - WholeW'(frac_s > FracW'(LimitDig))))
           || (whole_q == '0 && frac_s == '0);
  end

  always_comb begin
    b_amount_d = '0;
    if (!a_bad_q) begin
      b_amount_d = (AmountW'(a_whole_q) << 6) + (AmountW'(a_whole_q) << 5)
                 + (AmountW'(a_whole_q) << 2) + AmountW'(a_frac_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && is_end) begin
      a_bad_q   <= a_bad_d;
      a_whole_q <= whole_q;
      a_frac_q  <= frac_s;
    end
    if (a_vld_q && b_en) begin
      b_status_q <= a_bad_q;
      b_amount_q <= b_amount_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      whole_q    <= '0;
      frac_q     <= '0;
      fcnt_q     <= '0;
      seen_dig_q <= 1'b0;
      seen_pt_q  <= 1'b0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
    end else begin
      if (step) begin
        phase_q    <= phase_d;
        whole_q    <= whole_d;
        frac_q     <= frac_d;
        fcnt_q     <= fcnt_d;
        seen_dig_q <= seen_dig_d;
        seen_pt_q  <= seen_pt_d;
      end
      if (a_en) begin
        a_vld_q <= step && is_end;
      end
      if (b_en) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  assign out_valid_o = b_vld_q;
  assign status_o    = b_status_q;
  assign amount_o    = b_amount_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_ERR) else $error("phase left its code range");

  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 2'd2) else $error("more than two fraction digits stored");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && is_end) |=> (phase_q == PH_LEAD && !seen_dig_q && whole_q == '0))
    else $error("terminator did not clear parser state");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_status_q) |-> (b_amount_q == '0))
    else $error("rejected string carries a nonzero amount");

endmodule

FILE: rtl/core/decimal_amount_text_to_cents.sv
// Decimal amount text parser, top level: joins the classifying front end
// and the grammar/result back end. Depends on datc_pkg, datc_front, datc_back.
//
// Takes one character per transfer on the slave side and sustains one
// character per cycle while the token queue has room; a zero byte ends the
// string. A four-entry token queue sits between the byte classifier and the
// grammar engine, so either side can stall alone. On the terminator the
// engine registers the finished string in a finish stage, the output register
// then holds status (tuser: 0 valid, 1 invalid) and the amount in hundredths
// (0 when invalid). The output register and finish stage let input flow on
// while a result waits.
module decimal_amount_text_to_cents import datc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [62:0] amount, [63] zero fill
  output logic [0:0]  m_axis_tuser_o    // [0] status
);

  logic               tok_valid, tok_pop;
  token_t             tok;
  logic               status;
  logic [AmountW-1:0] amount;

  datc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .ch_i        (s_axis_tdata_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  datc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .amount_o    (amount)
  );

  assign m_axis_tdata_o = {1'b0, amount};
  assign m_axis_tuser_o = status;

endmodule

FILE: verif/decimal_amount_text_to_cents_tb.sv
// Self-checking testbench for decimal_amount_text_to_cents: streams amount
// strings in, predicts status and hundredths per terminator, checks results.
// Depends on datc_pkg and the decimal_amount_text_to_cents top level.
module decimal_amount_text_to_cents_tb;
  import datc_pkg::*;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_TRAIL,
    SCAN_ERR
  } scan_phase_e;

  typedef struct packed {
    logic               status;
    logic [AmountW-1:0] amount;
  } cents_result_t;

  localparam logic [63:0] AmountCeil  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic        StatusOk    = 1'b0;
  localparam logic        StatusBad   = 1'b1;
  localparam logic [7:0]  ChEnd       = 8'h00;
  localparam logic [7:0]  ChTab       = 8'h09;
  localparam logic [7:0]  ChCr        = 8'h0D;
  localparam logic [7:0]  ChSpace     = 8'h20;
  localparam logic [7:0]  ChPoint     = 8'h2E;
  localparam logic [7:0]  ChZero      = 8'h30;
  localparam logic [7:0]  ChMaxByte   = 8'hFF;
  localparam int unsigned PhaseItems  = 500;
  localparam int unsigned StallLen    = 300;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  decimal_amount_text_to_cents u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] ch
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [62:0] amount, [63] zero fill
    .m_axis_tuser_o  (m_axis_tuser_o)    // [0] status
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]    text_q[$];
  cents_result_t cents_q[$];
  int unsigned   src_idle_pct = 0;
  int unsigned   snk_idle_pct = 0;
  bit            offering     = 1'b0;
  bit            in_xfer      = 1'b0;
  bit            stall_req    = 1'b0;
  int unsigned   stall_left   = 0;
  int unsigned   idle_cycles  = 0;
  int unsigned   err_cnt      = 0;

  // predicted parser state
  scan_phase_e       scan_ph  = SCAN_LEAD;
  logic [WholeW-1:0] whole    = '0;
  logic [FracW-1:0]  frac     = '0;
  logic [1:0]        frac_cnt = '0;
  logic              seen_dig = 1'b0;
  logic              seen_pt  = 1'b0;

  function automatic bit is_space(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChZero + 8'd9;
  endfunction

  task automatic take_int_digit(input logic [3:0] d);
    if ({4'b0, whole} > (AmountCeil - {60'b0, d}) / 64'd100) begin
      scan_ph = SCAN_ERR;
    end else begin
      whole    = whole * 60'd10 + {56'b0, d};
      seen_dig = 1'b1;
      scan_ph  = SCAN_INT;
    end
  endtask

  task automatic scan_amount_char(input logic [7:0] c);
    logic [63:0]   fval;
    logic [63:0]   total;
    cents_result_t res;
    if (c == ChEnd) begin
      res.status = StatusBad;
      res.amount = '0;
      if (scan_ph <= SCAN_TRAIL && seen_dig && !(seen_pt && frac_cnt == 0)) begin
        fval = (frac_cnt == 0) ? 64'd0 :
               (frac_cnt == 1) ? {57'b0, frac} * 64'd10 : {57'b0, frac};
        if ({4'b0, whole} <= (AmountCeil - fval) / 64'd100) begin
          total = {4'b0, whole} * 64'd100 + fval;
          if (total != 0) begin
            res.status = StatusOk;
            res.amount = total[AmountW-1:0];
          end
        end
      end
      cents_q.push_back(res);
      scan_ph  = SCAN_LEAD;
      whole    = '0;
      frac     = '0;
      frac_cnt = '0;
      seen_dig = 1'b0;
      seen_pt  = 1'b0;
    end else begin
      case (scan_ph)
        SCAN_LEAD: begin
          if (is_digit(c)) begin
            take_int_digit(c[3:0]);
          end else if (c == ChPoint) begin
            seen_pt = 1'b1;
            scan_ph = SCAN_FRAC;
          end else if (!is_space(c)) begin
            scan_ph = SCAN_ERR;
          end
        end
        SCAN_INT: begin
          if (is_digit(c)) begin
            take_int_digit(c[3:0]);
          end else if (c == ChPoint) begin
            seen_pt = 1'b1;
            scan_ph = SCAN_FRAC;
          end else if (is_space(c)) begin
            scan_ph = SCAN_TRAIL;
          end else begin
            scan_ph = SCAN_ERR;
          end
        end
        SCAN_FRAC: begin
          if (is_digit(c)) begin
            if (frac_cnt >= 2) begin
              scan_ph = SCAN_ERR;
            end else begin
              frac     = frac * 7'd10 + {3'b0, c[3:0]};
              frac_cnt = frac_cnt + 2'd1;
              seen_dig = 1'b1;
            end
          end else if (is_space(c)) begin
            scan_ph = SCAN_TRAIL;
          end else begin
            scan_ph = SCAN_ERR;
          end
        end
        SCAN_TRAIL: begin
          if (!is_space(c)) begin
            scan_ph = SCAN_ERR;
          end
        end
        default: begin
          scan_ph = SCAN_ERR;
        end
      endcase
    end
  endtask

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? ChSpace : ChTab + 8'(r);
  endfunction

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  // Mostly well-formed amounts with random content; some near the signed
  // 64-bit limit, some all zeros, some corrupted, and some pure noise.
  function automatic int unsigned push_random_string();
    logic [7:0]  txt[$];
    string       head;
    int unsigned i;
    int unsigned n;
    int unsigned tail;
    bit          near;
    bit          zeros;
    head = "922337203685477";
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(6)) txt.push_back(8'($urandom_range(255, 1)));
    end else begin
      near  = $urandom_range(99) < 10;
      zeros = $urandom_range(9) == 0;
      repeat ($urandom_range(2)) txt.push_back(rand_space());
      if (near) begin
        for (i = 0; i < head.len(); i++) txt.push_back(head[i]);
        tail = $urandom_range(3);
        if (tail == 0) begin
          txt.push_back("5");
          txt.push_back("7");
        end else if (tail == 1) begin
          txt.push_back("5");
          txt.push_back("8");
        end else begin
          repeat ($urandom_range(3, 2)) txt.push_back(ChZero + 8'($urandom_range(9)));
        end
      end else begin
        n = ($urandom_range(99) < 15) ? 0 : $urandom_range(5, 1);
        repeat (n) txt.push_back(zeros ? ChZero : ChZero + 8'($urandom_range(9)));
      end
      if (near || $urandom_range(99) < 60) begin
        txt.push_back(ChPoint);
        n = ($urandom_range(99) < 10) ? 3 * $urandom_range(1) : $urandom_range(2, 1);
        for (i = 0; i < n; i++) begin
          if (zeros || (near && i == 0 && $urandom_range(1) == 1)) begin
            txt.push_back(ChZero);
          end else begin
            txt.push_back(ChZero + 8'($urandom_range(9)));
          end
        end
      end
      repeat ($urandom_range(2)) txt.push_back(rand_space());
      if ($urandom_range(99) < 15 && txt.size() != 0) begin
        txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255, 1));
      end
    end
    foreach (txt[k]) text_q.push_back(txt[k]);
    text_q.push_back(ChEnd);
    return txt.size() + 1;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (in_xfer) begin
      in_xfer  = 1'b0;
      offering = 1'b0;
    end
    if (!offering) begin
      if (rst_ni && text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tdata_i  <= text_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        offering = 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = StallLen;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (cents_q.size() == 0) begin
          $error("result with no expectation: status %0d amount %0d",
                 m_axis_tuser_o[0], m_axis_tdata_o[AmountW-1:0]);
          err_cnt++;
        end else begin
          if (m_axis_tuser_o[0] !== cents_q[0].status) begin
            $error("status mismatch: expected %0d, got %0d",
                   cents_q[0].status, m_axis_tuser_o[0]);
            err_cnt++;
          end
          if (m_axis_tdata_o[AmountW-1:0] !== cents_q[0].amount) begin
            $error("amount mismatch: expected %0d, got %0d",
                   cents_q[0].amount, m_axis_tdata_o[AmountW-1:0]);
            err_cnt++;
          end
          void'(cents_q.pop_front());
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_amount_char(s_axis_tdata_i);
        in_xfer = 1'b1;
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pass_i;
    int unsigned fed;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (pass_i = 0; pass_i < 3; pass_i++) begin
      case (pass_i)
        0: begin
          src_idle_pct = 29;
          snk_idle_pct = 72;
        end
        1: begin
          src_idle_pct = 72;
          snk_idle_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          stall_req    = 1'b1;
        end
      endcase
      if (pass_i == 0) begin
        text_q.push_back(ChTab);
        push_text("7.25");
        text_q.push_back(ChCr);
        text_q.push_back(ChEnd);
        push_text("+1");
        text_q.push_back(ChEnd);
        push_text(".");
        text_q.push_back(ChEnd);
        push_text("0.00");
        text_q.push_back(ChEnd);
        push_text("1.234");
        text_q.push_back(ChEnd);
        push_text("1 2");
        text_q.push_back(ChEnd);
        text_q.push_back(ChMaxByte);
        text_q.push_back(ChEnd);
      end
      fed = 0;
      while (fed < PhaseItems) fed += push_random_string();
      while (text_q.size() != 0 || offering || cents_q.size() != 0) @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/datc_pkg.sv
rtl/core/datc_front.sv
rtl/core/datc_back.sv
rtl/core/decimal_amount_text_to_cents.sv
verif/decimal_amount_text_to_cents_tb.sv
